// ----- rtl/mi3_pkg.sv -----
// Shared types, defaults and the cofactor index table for the 3x3 matrix inverse.
package mi3_pkg;

	localparam int ELEMENT_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int ELEM_PORT_WIDTH   = 32;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_CA,
		S_CB,
		S_CC,
		S_CD,
		S_DA,
		S_DB,
		S_DC,
		S_DD,
		S_PREP,
		S_QLOAD,
		S_QWAIT,
		S_EMIT
	} state_t;

	// Divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	// Store indices {a, b, c, d} of cofactor k = a*b - c*d, row-major adjugate order
	function automatic logic [15:0] cof_idx(input logic [3:0] k);
		logic [15:0] r;
		case (k)
			4'd0: r = {4'd4, 4'd8, 4'd5, 4'd7};
			4'd1: r = {4'd7, 4'd2, 4'd1, 4'd8};
			4'd2: r = {4'd1, 4'd5, 4'd2, 4'd4};
			4'd3: r = {4'd6, 4'd5, 4'd3, 4'd8};
			4'd4: r = {4'd0, 4'd8, 4'd6, 4'd2};
			4'd5: r = {4'd2, 4'd3, 4'd0, 4'd5};
			4'd6: r = {4'd3, 4'd7, 4'd6, 4'd4};
			4'd7: r = {4'd1, 4'd6, 4'd0, 4'd7};
			4'd8: r = {4'd0, 4'd4, 4'd1, 4'd3};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/mi3_div.sv -----
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
module mi3_div #(
	parameter int NW = 96,
	parameter int DW = 99
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [NW-1:0]        numer,
	input  logic [DW-1:0]        denom,
	output mi3_pkg::div_status_t status,
	output logic [NW-1:0]        quot
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [DW:0]   rem_sh;
	logic [DW:0]   trial;

	// Shift in the next numerator bit and try the subtraction
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign trial  = rem_sh - {1'b0, den_q};

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					done_q <= 1'b1;
			end
		end
	end

	// Datapath: quotient bits enter at the bottom of the numerator register
	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (cnt_q != '0) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end

	assign status.busy = (cnt_q != '0);
	assign status.done = done_q;
	assign quot        = num_q;

endmodule

// ----- rtl/matrix_inverse_3x3.sv -----
// 3x3 matrix inverse by the adjugate: element loader, shared multiplier, sequencer.
// Loads nine signed fixed-point elements row-major, one per start while busy is low.
// After the ninth, busy rises and one shared multiplier forms the nine cofactors and
// the determinant; then a bit-serial divider produces each result in turn, and a
// singular matrix skips the divider and gives zero results.
// Each result is shown for one cycle with done high and cannot be held off: the
// receiver must take it then. busy falls in the cycle the ninth result is shown.
module matrix_inverse_3x3 #(
	parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF,
	parameter int FRAC_BITS     = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] element,
	output logic        busy,
	output logic        done,
	output logic [31:0] value,
	output logic [1:0]  row,
	output logic [1:0]  column,
	output logic        last,
	output logic        singular,
	output logic        saturated
);

	localparam int W  = ELEMENT_WIDTH;
	localparam int PW = 2 * W + 2;          // multiplier product
	localparam int CW = 2 * W + 1;          // cofactor
	localparam int DW = 3 * W + 3;          // determinant
	localparam int NW = 2 * W + 2 * FRAC_BITS;

	mi3_pkg::state_t state_q, state_d;

	logic [3:0]        load_cnt_q;
	logic [3:0]        k_q;
	logic [W-1:0]      mem [9];
	logic [W-1:0]      rd0_q, rd1_q;
	logic [3:0]        raddr0, raddr1;
	logic [15:0]       idx;
	logic signed [W:0] opa, opb;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] acc_q;
	logic signed [CW-1:0] cof_q [9];
	logic signed [CW-1:0] cof_k;
	logic signed [DW-1:0] det_q;
	logic signed [DW-1:0] prod_ext;
	logic [DW-1:0]     dmag_q;
	logic              sing_q, dneg_q, nneg_q;
	logic [CW-1:0]     cmag;
	logic [NW-1:0]     numer;
	logic              div_load;
	mi3_pkg::div_status_t div_st;
	logic [NW-1:0]     quot;
	logic              accept;
	logic              rneg;
	logic [NW-1:0]     lim;
	logic              sat_c;
	logic [W-1:0]      qclip;
	logic signed [W-1:0] val_c;
	logic [1:0]        row_c, col_c;

	logic              done_q, last_q, sing_out_q, sat_q;
	logic [31:0]       value_q;
	logic [1:0]        row_q, col_q;

	assign accept = start && (state_q == mi3_pkg::S_IDLE);
	assign idx    = mi3_pkg::cof_idx(k_q);
	assign cof_k  = cof_q[k_q];

	// Element store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (accept)
			mem[load_cnt_q] <= element[W-1:0];
		rd0_q <= mem[raddr0];
		rd1_q <= mem[raddr1];
	end

	// Read address selection; first-column element held over both determinant products
	always_comb begin
		raddr0 = idx[15:12];
		raddr1 = idx[11:8];
		case (state_q)
			mi3_pkg::S_CB: begin
				raddr0 = idx[7:4];
				raddr1 = idx[3:0];
			end
			mi3_pkg::S_DA, mi3_pkg::S_DB: begin
				raddr0 = 4'(k_q * 4'd3);
				raddr1 = 4'(k_q * 4'd3);
			end
			default: ;
		endcase
	end

	// Shared multiplier operands
	always_comb begin
		opa = {rd0_q[W-1], rd0_q};
		case (state_q)
			mi3_pkg::S_DB: opb = {1'b0, cof_k[W-1:0]};
			mi3_pkg::S_DC: opb = cof_k[CW-1:W];
			default:       opb = {rd1_q[W-1], rd1_q};
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(opa * opb);
	end

	assign prod_ext = {{(DW - PW){prod_q[PW-1]}}, prod_q};

	// Magnitude of the current cofactor, scaled for the quotient
	assign cmag     = cof_k[CW-1] ? CW'(-cof_k) : CW'(cof_k);
	assign numer    = {cmag[2*W-1:0], {(2 * FRAC_BITS){1'b0}}};
	assign div_load = (state_q == mi3_pkg::S_QLOAD) && !sing_q;

	mi3_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (div_load),
		.numer  (numer),
		.denom  (dmag_q),
		.status (div_st),
		.quot   (quot)
	);

	// Sign fix-up and clipping of the quotient
	assign rneg  = nneg_q ^ dneg_q;
	assign lim   = NW'({1'b1, {(W - 1){1'b0}}}) - NW'(!rneg);
	assign sat_c = quot > lim;
	assign qclip = sat_c ? lim[W-1:0] : quot[W-1:0];
	assign val_c = sing_q ? '0 : (rneg ? -qclip : qclip);

	// Row and column of the current result
	always_comb begin
		if (k_q >= 4'd6) begin
			row_c = 2'd2;
			col_c = 2'(k_q - 4'd6);
		end else if (k_q >= 4'd3) begin
			row_c = 2'd1;
			col_c = 2'(k_q - 4'd3);
		end else begin
			row_c = 2'd0;
			col_c = k_q[1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mi3_pkg::S_IDLE:  if (accept && load_cnt_q == 4'd8) state_d = mi3_pkg::S_CA;
			mi3_pkg::S_CA:    state_d = mi3_pkg::S_CB;
			mi3_pkg::S_CB:    state_d = mi3_pkg::S_CC;
			mi3_pkg::S_CC:    state_d = mi3_pkg::S_CD;
			mi3_pkg::S_CD:    state_d = (k_q == 4'd8) ? mi3_pkg::S_DA : mi3_pkg::S_CA;
			mi3_pkg::S_DA:    state_d = mi3_pkg::S_DB;
			mi3_pkg::S_DB:    state_d = mi3_pkg::S_DC;
			mi3_pkg::S_DC:    state_d = mi3_pkg::S_DD;
			mi3_pkg::S_DD:    state_d = (k_q == 4'd2) ? mi3_pkg::S_PREP : mi3_pkg::S_DA;
			mi3_pkg::S_PREP:  state_d = mi3_pkg::S_QLOAD;
			mi3_pkg::S_QLOAD: state_d = sing_q ? mi3_pkg::S_EMIT : mi3_pkg::S_QWAIT;
			mi3_pkg::S_QWAIT: if (div_st.done) state_d = mi3_pkg::S_EMIT;
			mi3_pkg::S_EMIT:  state_d = (k_q == 4'd8) ? mi3_pkg::S_IDLE : mi3_pkg::S_QLOAD;
			default:          state_d = mi3_pkg::S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mi3_pkg::S_IDLE;
			load_cnt_q <= '0;
			k_q        <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == mi3_pkg::S_EMIT);
			if (accept)
				load_cnt_q <= (load_cnt_q == 4'd8) ? 4'd0 : load_cnt_q + 4'd1;
			case (state_q)
				mi3_pkg::S_IDLE: k_q <= '0;
				mi3_pkg::S_CD:   k_q <= (k_q == 4'd8) ? 4'd0 : k_q + 4'd1;
				mi3_pkg::S_DD:   k_q <= (k_q == 4'd2) ? 4'd0 : k_q + 4'd1;
				mi3_pkg::S_EMIT: k_q <= (k_q == 4'd8) ? 4'd0 : k_q + 4'd1;
				default: ;
			endcase
		end
	end

	// Cofactor, determinant and result datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mi3_pkg::S_CC: acc_q <= prod_q;
			mi3_pkg::S_CD: begin
				cof_q[k_q] <= CW'(acc_q - prod_q);
				if (k_q == 4'd8)
					det_q <= '0;
			end
			mi3_pkg::S_DC: det_q <= det_q + prod_ext;
			mi3_pkg::S_DD: det_q <= det_q + (prod_ext <<< W);
			mi3_pkg::S_PREP: begin
				sing_q <= (det_q == '0);
				dneg_q <= det_q[DW-1];
				dmag_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
			end
			mi3_pkg::S_QLOAD: nneg_q <= cof_k[CW-1];
			mi3_pkg::S_EMIT: begin
				value_q    <= 32'(val_c);
				row_q      <= row_c;
				col_q      <= col_c;
				last_q     <= (k_q == 4'd8);
				sing_out_q <= sing_q;
				sat_q      <= !sing_q && sat_c;
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != mi3_pkg::S_IDLE);
	assign done      = done_q;
	assign value     = value_q;
	assign row       = row_q;
	assign column    = col_q;
	assign last      = last_q;
	assign singular  = sing_out_q;
	assign saturated = sat_q;

`ifndef ASSERT_OFF
	// A result only follows a cycle of work
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without preceding work");
	// Singular matrices give clean zero results
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && singular |-> value == 32'd0 && !saturated) else $error("singular result not zero");
	// The final result sits at the bottom-right corner
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |-> row == 2'd2 && column == 2'd2) else $error("last at wrong position");
	// The ninth element starts the computation
	a_ninth_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && load_cnt_q == 4'd8 |=> busy) else $error("ninth item did not start work");
`endif

endmodule
